// ----- rtl/strc_pkg.sv -----
// strc_pkg: shared types, codes and the combine function for the segment tree unit
// used by strc_ctrl, strc_datapath and segment_tree_range_combine_unit
// no dependencies
package strc_pkg;

	// default number of leaves
	localparam int unsigned LEAVES_DEF = 1024;

	// fixed field widths
	localparam int unsigned START_W = 10;
	localparam int unsigned END_W   = 11;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// operation codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// combine modes
	localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDENTITY_VALUE = 1'd1;

	// configuration reset values
	localparam logic [MODE_W-1:0] MODE_RESET     = MODE_MIN;
	localparam logic [DATA_W-1:0] IDENTITY_RESET = 32'h7FFF_FFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic clr_step;   // write zero to next node of the clearing pass
		logic load_upd;   // capture leaf index and new value
		logic load_qry;   // capture span borders, seed accumulator
		logic leaf_wr;    // write the new leaf value
		logic u_step;     // read sibling, move one level up
		logic q_step;     // one border step of the query walk
	} strc_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;   // clearing pass at last node
		logic idx_ok;     // update index inside the leaves
		logic k_gt1;      // update walk not yet at root
		logic a_lt_b;     // query borders not yet met
	} strc_status_t;

	// signed minimum, signed maximum or wrapping sum; unused mode acts as minimum
	function automatic logic [DATA_W-1:0] combine(
		input logic [MODE_W-1:0] mode,
		input logic [DATA_W-1:0] x,
		input logic [DATA_W-1:0] y
	);
		logic x_lt_y;
		logic y_lt_x;
		x_lt_y = $signed(x) < $signed(y);
		y_lt_x = $signed(y) < $signed(x);
		case (mode)
			MODE_MAX: begin
				combine = x_lt_y ? y : x;
			end
			MODE_SUM: begin
				combine = x + y;
			end
			default: begin
				combine = y_lt_x ? y : x;
			end
		endcase
	endfunction

endpackage

// ----- rtl/segment_tree_range_combine_unit.sv -----
// segment_tree_range_combine_unit: top level of the segment tree point update / range query unit
// depends on strc_pkg, strc_ctrl, strc_datapath (and through it strc_ram)
//
// usage
//   command channel: an item transfers on a rising edge with start high and busy low.
//   operation selects a point update (write leaf start_index with value, then
//   recombine every ancestor up to the root) or a range query over the half-open
//   leaf span start_index .. end_index; end_index is clamped to LEAVES, and an
//   empty or reversed span returns identity_value. updates of an index at or
//   beyond LEAVES are dropped without going busy.
//   result channel: each query gives one result_value, shown for exactly one cycle
//   with result_valid high; the receiver cannot stall it. updates give no result.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
//   combine mode (min, max, wrapping sum; unused code acts as min), index 1 the
//   identity value. cfg_ready is always high; write only while the unit is idle.
// timing
//   an update keeps busy high through one leaf write, then one
//   level per cycle, the sibling read overlapping the previous parent write.
//   a query needs up to two node reads per tree level through the single ram read
//   port, at most one per step of the query walk.
// reset
//   all nodes are cleared to zero by a pass with busy high; config writes are
//   taken during that pass.
module segment_tree_range_combine_unit #(
	parameter int unsigned LEAVES = strc_pkg::LEAVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [strc_pkg::START_W-1:0]        start_index,
	input  logic [strc_pkg::END_W-1:0]          end_index,
	input  logic signed [strc_pkg::DATA_W-1:0]  value,
	// result channel
	output logic                                result_valid,
	output logic signed [strc_pkg::DATA_W-1:0]  result_value,
	// config channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [strc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [strc_pkg::DATA_W-1:0]         cfg_data
);

	strc_pkg::strc_cmd_t    cmd;
	strc_pkg::strc_status_t status;

	// config registers sit in the datapath and accept every cycle
	assign cfg_ready = 1'b1;

	strc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	strc_datapath #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.start_index  (start_index),
		.end_index    (end_index),
		.value        (value),
		.cfg_wr       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_value (result_value)
	);

endmodule

// ----- rtl/strc_ram.sv -----
// strc_ram: generic single write port, single read port ram with registered read
// no dependencies
module strc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/strc_ctrl.sv -----
// strc_ctrl: sequencing state machine of the segment tree unit
// depends on strc_pkg for command and status structs and codes
module strc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  operation,
	input  strc_pkg::strc_status_t status,
	output strc_pkg::strc_cmd_t   cmd,
	output logic                  busy,
	output logic                  result_valid
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_U_LEAF = 6'b000100,
		S_U_WALK = 6'b001000,
		S_Q_WALK = 6'b010000,
		S_Q_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (operation == strc_pkg::OP_QUERY) begin
						cmd.load_qry = 1'b1;
						state_d      = S_Q_WALK;
					end else if (status.idx_ok) begin
						cmd.load_upd = 1'b1;
						state_d      = S_U_LEAF;
					end
				end
			end
			S_U_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_d     = S_U_WALK;
			end
			S_U_WALK: begin
				// last parent write lands on the edge that leaves this state
				if (status.k_gt1) begin
					cmd.u_step = 1'b1;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_Q_WALK: begin
				if (status.a_lt_b) begin
					cmd.q_step = 1'b1;
				end else begin
					state_d = S_Q_OUT;
				end
			end
			S_Q_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_Q_OUT);

endmodule

// ----- rtl/strc_datapath.sv -----
// strc_datapath: node store, border registers, combine unit and configuration registers
// depends on strc_pkg and strc_ram
module strc_datapath #(
	parameter int unsigned LEAVES = strc_pkg::LEAVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  strc_pkg::strc_cmd_t                 cmd,
	output strc_pkg::strc_status_t              status,
	input  logic [strc_pkg::START_W-1:0]        start_index,
	input  logic [strc_pkg::END_W-1:0]          end_index,
	input  logic signed [strc_pkg::DATA_W-1:0]  value,
	input  logic                                cfg_wr,
	input  logic [strc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [strc_pkg::DATA_W-1:0]         cfg_data,
	output logic signed [strc_pkg::DATA_W-1:0]  result_value
);

	localparam int unsigned DW    = strc_pkg::DATA_W;
	localparam int unsigned IDX_W = $clog2(2 * LEAVES + 1);
	localparam int unsigned AW    = $clog2(2 * LEAVES);
	localparam int unsigned IN_W  =
		((IDX_W > strc_pkg::END_W) ? IDX_W : strc_pkg::END_W) + 1;
	localparam logic [IN_W-1:0] LEAVES_IN = IN_W'(LEAVES);
	localparam logic [AW-1:0]   CLR_LAST  = AW'(2 * LEAVES - 1);

	// configuration
	logic [strc_pkg::MODE_W-1:0] mode_q;
	logic [DW-1:0]               ident_q;

	// walk state
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] a_q;
	logic [IDX_W-1:0] b_q;
	logic [DW-1:0]    carry_q;
	logic [DW-1:0]    acc_q;
	logic [AW-1:0]    clr_q;

	// read pipeline stage
	logic          pend_s1;
	logic          pend_upd_s1;
	logic [AW-1:0] par_s1;

	// input decode
	logic [IN_W-1:0] lo_w;
	logic [IN_W-1:0] hi_w;
	logic [IN_W-1:0] hi_c;
	logic [IN_W-1:0] lo_sum;
	logic [IN_W-1:0] hi_sum;
	logic [IN_W-1:0] a_sum;
	logic            span_ok;

	// address arithmetic
	logic [IDX_W-1:0] sib;
	logic [IDX_W-1:0] k_half;
	logic [IDX_W-1:0] a_inc;
	logic [IDX_W-1:0] b_dec;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	logic [DW-1:0] comb_in;
	logic [DW-1:0] comb_out;

	assign lo_w    = IN_W'(start_index);
	assign hi_w    = IN_W'(end_index);
	assign hi_c    = (hi_w > LEAVES_IN) ? LEAVES_IN : hi_w;
	assign span_ok = lo_w < hi_c;
	assign lo_sum  = lo_w + LEAVES_IN;
	assign hi_sum  = hi_c + LEAVES_IN;
	// empty span starts with both borders equal
	assign a_sum   = span_ok ? lo_sum : hi_sum;

	assign sib    = {k_q[IDX_W-1:1], ~k_q[0]};
	assign k_half = k_q >> 1;
	assign a_inc  = a_q + IDX_W'(1);
	assign b_dec  = b_q - IDX_W'(1);

	assign status.clr_last = (clr_q == CLR_LAST);
	assign status.idx_ok   = lo_w < LEAVES_IN;
	assign status.k_gt1    = k_q > IDX_W'(1);
	assign status.a_lt_b   = a_q < b_q;

	// read side
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (cmd.u_step) begin
			ram_re    = 1'b1;
			ram_raddr = sib[AW-1:0];
		end else if (cmd.q_step) begin
			ram_re    = a_q[0] | b_q[0];
			ram_raddr = a_q[0] ? a_q[AW-1:0] : b_dec[AW-1:0];
		end
	end

	assign comb_in  = pend_upd_s1 ? carry_q : acc_q;
	assign comb_out = strc_pkg::combine(mode_q, comb_in, ram_rdata);

	// write side
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = par_s1;
		ram_wdata = comb_out;
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.leaf_wr) begin
			ram_we    = 1'b1;
			ram_waddr = k_q[AW-1:0];
			ram_wdata = carry_q;
		end else if (pend_s1 && pend_upd_s1) begin
			ram_we = 1'b1;
		end
	end

	strc_ram #(
		.WIDTH (DW),
		.DEPTH (2 * LEAVES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= strc_pkg::MODE_RESET;
			ident_q     <= strc_pkg::IDENTITY_RESET;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			pend_upd_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					strc_pkg::REG_COMBINE_MODE: begin
						mode_q <= cfg_data[strc_pkg::MODE_W-1:0];
					end
					strc_pkg::REG_IDENTITY_VALUE: begin
						ident_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			pend_s1     <= ram_re;
			pend_upd_s1 <= cmd.u_step;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		par_s1 <= k_half[AW-1:0];
		if (cmd.load_upd) begin
			k_q     <= lo_sum[IDX_W-1:0];
			carry_q <= value;
		end else if (cmd.u_step) begin
			k_q <= k_half;
		end
		if (pend_s1 && pend_upd_s1) begin
			carry_q <= comb_out;
		end
		if (cmd.load_qry) begin
			a_q   <= a_sum[IDX_W-1:0];
			b_q   <= hi_sum[IDX_W-1:0];
			acc_q <= ident_q;
		end else begin
			if (pend_s1 && !pend_upd_s1) begin
				acc_q <= comb_out;
			end
			if (cmd.q_step) begin
				if (a_q[0]) begin
					if (b_q[0]) begin
						// right border still owes a node on this level
						a_q <= a_inc;
					end else begin
						a_q <= a_inc >> 1;
						b_q <= b_q >> 1;
					end
				end else if (b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_dec >> 1;
				end else begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end
			end
		end
	end

	assign result_value = $signed(acc_q);

endmodule

// ----- rtl/strc_checker.sv -----
// strc_checker: port level assertions for segment_tree_range_combine_unit, bound to the top level
// depends on strc_pkg
module strc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           operation,
	input logic                           result_valid
);

	// a result strobe lasts a single cycle
	ap_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// a query transfer always makes the unit busy
	ap_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == strc_pkg::OP_QUERY) |=> busy)
		else $error("query transfer did not raise busy");

	// results only come while busy
	ap_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	// the unit is free again right after a result
	ap_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("unit still busy after result");

endmodule

bind segment_tree_range_combine_unit strc_checker u_strc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.result_valid (result_valid)
);
